[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the I2C master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define I2CM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/i2cm_pkg.sv]
// Package with the types, codes and sequencer step functions of the I2C master.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DELAY, PH_CLKHI, PH_WAITFREE, PH_START_SDA, PH_START_SCL,
    PH_WB_BIT, PH_WB_RISE, PH_WB_FALL, PH_WB_ACKRISE, PH_WB_ACKSAMPLE, PH_WB_AFTER,
    PH_NEEDBYTE, PH_RS_BEGIN, PH_RS_RISE, PH_RB_BEGIN, PH_RB_RISE, PH_RB_SAMPLE,
    PH_RB_ACK, PH_RB_ACKRISE, PH_RB_ACKFALL, PH_RB_END, PH_ST_BEGIN, PH_ST_RISE,
    PH_ST_END, PH_ST_DONE, PH_RC_BEGIN, PH_RC_LOW, PH_RC_RISE, PH_RC_NEXT, PH_RC_OK
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK, ST_NACK, ST_TIMEOUT, ST_STUCK, ST_ARG
  } status_t;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PROBE   = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_RECOVER = 3'd4;
  localparam logic [2:0] OP_SUPPLY  = 3'd5;

  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_RECOVER = 2'd3;

  localparam logic [1:0] ROLE_ADDR  = 2'd0;
  localparam logic [1:0] ROLE_REG   = 2'd1;
  localparam logic [1:0] ROLE_RADDR = 2'd2;
  localparam logic [1:0] ROLE_DATA  = 2'd3;

  localparam logic [1:0] STAGE_XFER    = 2'd0;
  localparam logic [1:0] STAGE_STOP    = 2'd1;
  localparam logic [1:0] STAGE_RECOVER = 2'd2;
  localparam logic [1:0] STAGE_FINAL   = 2'd3;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_STRETCH     = 2'd1;
  localparam logic [1:0] CFG_BUS_FREE    = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [3:0] RECOVERY_PULSES = 4'd9;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  address;
    logic [7:0]  reg_index;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        scl_level;
    logic        sda_level;
  } item_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [15:0] stretch_timeout;
    logic [15:0] bus_free_timeout;
  } cfg_t;

  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        busy_res;
    logic        byte_request;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        read_last;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] errors_seen;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    phase_t      ret_phase;
    logic [3:0]  bit_cnt;
    logic [15:0] byte_cnt;
    logic [7:0]  shift_byte;
    logic [15:0] delay_cnt;
    logic [15:0] wait_cnt;
    logic [15:0] err_total;
    status_t     held_status;
    logic [6:0]  held_address;
    logic [7:0]  held_register;
    logic [15:0] held_length;
    logic [1:0]  held_kind;
    logic [1:0]  stage;
    logic [1:0]  role;
    logic        nack;
    logic        scl_drive;
    logic        sda_drive;
  } st_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done;
    status_t    status;
  } flags_t;

  typedef struct packed {
    st_t    s;
    flags_t r;
  } step_t;

  localparam st_t ST_RESET = '{
    phase: PH_IDLE, ret_phase: PH_IDLE, bit_cnt: 4'd0, byte_cnt: 16'd0,
    shift_byte: 8'd0, delay_cnt: 16'd0, wait_cnt: 16'd0, err_total: 16'd0,
    held_status: ST_OK, held_address: 7'd0, held_register: 8'd0,
    held_length: 16'd0, held_kind: 2'd0, stage: 2'd0, role: 2'd0,
    nack: 1'b0, scl_drive: 1'b1, sda_drive: 1'b1
  };

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic st_t go_delay(st_t s, logic [15:0] hp, phase_t ret);
    st_t n;
    logic [15:0] hpe;
    n = s;
    hpe = (hp == 16'd0) ? 16'd1 : hp;
    n.delay_cnt = hpe - 16'd1;
    n.ret_phase = ret;
    n.phase = (hpe == 16'd1) ? ret : PH_DELAY;
    return n;
  endfunction

  function automatic st_t go_clkhi(st_t s, phase_t ret);
    st_t n;
    n = s;
    n.scl_drive = 1'b1;
    n.wait_cnt = 16'd0;
    n.ret_phase = ret;
    n.phase = PH_CLKHI;
    return n;
  endfunction

  function automatic st_t go_waitfree(st_t s, phase_t ret);
    st_t n;
    n = s;
    n.scl_drive = 1'b1;
    n.sda_drive = 1'b1;
    n.wait_cnt = 16'd0;
    n.ret_phase = ret;
    n.phase = PH_WAITFREE;
    return n;
  endfunction

  function automatic step_t complete(step_t x, status_t st);
    x.r.done = 1'b1;
    x.r.status = st;
    x.s.scl_drive = 1'b1;
    x.s.sda_drive = 1'b1;
    x.s.phase = PH_IDLE;
    return x;
  endfunction

  function automatic step_t st_begin(step_t x, logic [15:0] hp);
    x.s.sda_drive = 1'b0;
    x.s = go_delay(x.s, hp, PH_ST_RISE);
    return x;
  endfunction

  function automatic step_t rc_low(step_t x, logic [15:0] hp);
    x.s.scl_drive = 1'b0;
    x.s = go_delay(x.s, hp, PH_RC_RISE);
    return x;
  endfunction

  function automatic step_t rc_begin(step_t x, logic [15:0] hp);
    x.s.sda_drive = 1'b1;
    x.s.bit_cnt = 4'd0;
    return rc_low(x, hp);
  endfunction

  function automatic step_t fail(step_t x, status_t code, logic [15:0] hp);
    if (x.s.stage == STAGE_XFER) begin
      x.s.held_status = code;
      x.s.stage = STAGE_STOP;
      x = st_begin(x, hp);
    end else if (x.s.stage == STAGE_STOP) begin
      if (x.s.held_status == ST_OK) begin
        x.s.held_status = code;
      end
      x.s.err_total = sat_inc(x.s.err_total);
      x.s.stage = STAGE_RECOVER;
      x = rc_begin(x, hp);
    end else begin
      if (x.s.held_kind == KIND_RECOVER) begin
        x.s.held_status = code;
      end
      x = complete(x, x.s.held_status);
    end
    return x;
  endfunction

  function automatic step_t begin_stop(step_t x, logic [15:0] hp);
    x.s.stage = STAGE_STOP;
    return st_begin(x, hp);
  endfunction

  function automatic step_t wb_bit(step_t x, logic [15:0] hp);
    if (x.s.bit_cnt < BITS_PER_BYTE) begin
      x.s.sda_drive = x.s.shift_byte[7];
      x.s = go_delay(x.s, hp, PH_WB_RISE);
    end else begin
      x.s.sda_drive = 1'b1;
      x.s = go_delay(x.s, hp, PH_WB_ACKRISE);
    end
    return x;
  endfunction

  function automatic step_t need_byte(step_t x, item_t it, logic [15:0] hp);
    if (it.opcode == OP_SUPPLY) begin
      x.s.shift_byte = it.data_byte;
      x.s.bit_cnt = 4'd0;
      x.s.role = ROLE_DATA;
      x = wb_bit(x, hp);
    end else begin
      x.s.phase = PH_NEEDBYTE;
    end
    return x;
  endfunction

  function automatic step_t start_sda(step_t x, logic [15:0] hp);
    x.s.sda_drive = 1'b0;
    x.s = go_delay(x.s, hp, PH_START_SCL);
    return x;
  endfunction

  function automatic step_t rs_begin(step_t x, logic [15:0] hp);
    x.s.sda_drive = 1'b1;
    x.s.shift_byte = {x.s.held_address, 1'b1};
    x.s.role = ROLE_RADDR;
    x.s = go_delay(x.s, hp, PH_RS_RISE);
    return x;
  endfunction

  function automatic step_t rb_begin(step_t x);
    x.s.sda_drive = 1'b1;
    x.s.bit_cnt = 4'd0;
    x.s.shift_byte = 8'd0;
    x.s = go_clkhi(x.s, PH_RB_SAMPLE);
    return x;
  endfunction

  function automatic step_t begin_tx(step_t x, item_t it, logic [1:0] kind);
    x.s.held_kind = kind;
    x.s.held_address = it.address;
    x.s.held_register = it.reg_index;
    x.s.held_length = it.length;
    x.s.held_status = ST_OK;
    x.s.stage = STAGE_XFER;
    x.s.byte_cnt = 16'd0;
    x.s.role = ROLE_ADDR;
    x.s.shift_byte = {it.address, 1'b0};
    x.s = go_waitfree(x.s, PH_START_SDA);
    return x;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cm_seq.sv]
// Bus sequencer state and the logic that advances it by one tick per transfer.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire i2cm_pkg::item_t   item,
  input  wire i2cm_pkg::cfg_t    cfg,
  output i2cm_pkg::result_t      res
);
  import i2cm_pkg::*;

  st_t   state;
  step_t x;
  logic [15:0] hp;
  logic [15:0] wait_inc;
  logic [16:0] byte_plus;
  logic [15:0] byte_inc;
  logic [3:0]  bit_inc;

  always_comb begin
    hp = cfg.half_period;
    x.s = state;
    x.r = '0;
    wait_inc = sat_inc(state.wait_cnt);
    byte_plus = {1'b0, state.byte_cnt} + 17'd1;
    byte_inc = sat_inc(state.byte_cnt);
    bit_inc = state.bit_cnt + 4'd1;
    unique case (state.phase)
      PH_IDLE: begin
        x.s.scl_drive = 1'b1;
        x.s.sda_drive = 1'b1;
        if (item.opcode == OP_PROBE) begin
          x = begin_tx(x, item, KIND_PROBE);
        end else if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
          if (item.length == 16'd0) begin
            x = complete(x, ST_ARG);
          end else if (item.opcode == OP_WRITE) begin
            x = begin_tx(x, item, KIND_WRITE);
          end else begin
            x = begin_tx(x, item, KIND_READ);
          end
        end else if (item.opcode == OP_RECOVER) begin
          x.s.held_kind = KIND_RECOVER;
          x.s.held_status = ST_OK;
          x.s.stage = STAGE_RECOVER;
          x = rc_begin(x, hp);
        end
      end
      PH_DELAY: begin
        if (state.delay_cnt != 16'd0) begin
          x.s.delay_cnt = state.delay_cnt - 16'd1;
        end
        if (x.s.delay_cnt == 16'd0) begin
          x.s.phase = state.ret_phase;
        end
      end
      PH_CLKHI: begin
        x.s.scl_drive = 1'b1;
        if (item.scl_level) begin
          x.s = go_delay(x.s, hp, state.ret_phase);
        end else begin
          x.s.wait_cnt = wait_inc;
          if (wait_inc >= cfg.stretch_timeout) begin
            x = fail(x, ST_TIMEOUT, hp);
          end
        end
      end
      PH_WAITFREE: begin
        x.s.scl_drive = 1'b1;
        x.s.sda_drive = 1'b1;
        if (item.scl_level && item.sda_level) begin
          if (state.ret_phase == PH_START_SDA) begin
            x = start_sda(x, hp);
          end else begin
            x = complete(x, state.held_status);
          end
        end else begin
          x.s.wait_cnt = wait_inc;
          if (wait_inc >= cfg.bus_free_timeout) begin
            x = fail(x, ST_STUCK, hp);
          end
        end
      end
      PH_START_SDA: x = start_sda(x, hp);
      PH_START_SCL: begin
        x.s.scl_drive = 1'b0;
        x.s.bit_cnt = 4'd0;
        x.s = go_delay(x.s, hp, PH_WB_BIT);
      end
      PH_WB_BIT: x = wb_bit(x, hp);
      PH_WB_RISE: x.s = go_clkhi(x.s, PH_WB_FALL);
      PH_WB_FALL: begin
        x.s.scl_drive = 1'b0;
        x.s.shift_byte = {state.shift_byte[6:0], 1'b0};
        x.s.bit_cnt = bit_inc;
        x.s = go_delay(x.s, hp, PH_WB_BIT);
      end
      PH_WB_ACKRISE: x.s = go_clkhi(x.s, PH_WB_ACKSAMPLE);
      PH_WB_ACKSAMPLE: begin
        x.s.nack = item.sda_level;
        x.s.scl_drive = 1'b0;
        x.s = go_delay(x.s, hp, PH_WB_AFTER);
      end
      PH_WB_AFTER: begin
        if (state.nack) begin
          x = fail(x, ST_NACK, hp);
        end else begin
          unique case (state.role)
            ROLE_ADDR: begin
              if (state.held_kind == KIND_WRITE) begin
                x = need_byte(x, item, hp);
              end else if (state.held_kind == KIND_READ) begin
                x.s.shift_byte = state.held_register;
                x.s.role = ROLE_REG;
                x.s.bit_cnt = 4'd0;
                x = wb_bit(x, hp);
              end else begin
                x = begin_stop(x, hp);
              end
            end
            ROLE_REG: x = rs_begin(x, hp);
            ROLE_RADDR: begin
              x.s.byte_cnt = 16'd0;
              x = rb_begin(x);
            end
            default: begin
              x.s.byte_cnt = byte_inc;
              if (byte_inc < state.held_length) begin
                x = need_byte(x, item, hp);
              end else begin
                x = begin_stop(x, hp);
              end
            end
          endcase
        end
      end
      PH_NEEDBYTE: x = need_byte(x, item, hp);
      PH_RS_BEGIN: x = rs_begin(x, hp);
      PH_RS_RISE: x.s = go_clkhi(x.s, PH_START_SDA);
      PH_RB_BEGIN: x = rb_begin(x);
      PH_RB_RISE: x.s = go_clkhi(x.s, PH_RB_SAMPLE);
      PH_RB_SAMPLE: begin
        x.s.shift_byte = {state.shift_byte[6:0], item.sda_level};
        x.s.bit_cnt = bit_inc;
        x.s.scl_drive = 1'b0;
        x.s = go_delay(x.s, hp, (bit_inc < BITS_PER_BYTE) ? PH_RB_RISE : PH_RB_ACK);
      end
      PH_RB_ACK: begin
        x.s.sda_drive = (byte_plus < {1'b0, state.held_length}) ? 1'b0 : 1'b1;
        x.s = go_delay(x.s, hp, PH_RB_ACKRISE);
      end
      PH_RB_ACKRISE: x.s = go_clkhi(x.s, PH_RB_ACKFALL);
      PH_RB_ACKFALL: begin
        x.s.scl_drive = 1'b0;
        x.s = go_delay(x.s, hp, PH_RB_END);
      end
      PH_RB_END: begin
        x.s.sda_drive = 1'b1;
        x.r.read_valid = 1'b1;
        x.r.read_byte = state.shift_byte;
        x.r.read_last = (byte_plus >= {1'b0, state.held_length});
        x.s.byte_cnt = byte_inc;
        if (byte_inc < state.held_length) begin
          x = rb_begin(x);
        end else begin
          x = begin_stop(x, hp);
        end
      end
      PH_ST_BEGIN: x = st_begin(x, hp);
      PH_ST_RISE: x.s = go_clkhi(x.s, PH_ST_END);
      PH_ST_END: begin
        x.s.sda_drive = 1'b1;
        x.s = go_delay(x.s, hp, PH_ST_DONE);
      end
      PH_ST_DONE: begin
        if (state.stage == STAGE_STOP) begin
          if (state.held_status == ST_OK) begin
            x = complete(x, ST_OK);
          end else begin
            x.s.err_total = sat_inc(state.err_total);
            x.s.stage = STAGE_RECOVER;
            x = rc_begin(x, hp);
          end
        end else begin
          x.s = go_waitfree(x.s, PH_RC_OK);
        end
      end
      PH_RC_BEGIN: x = rc_begin(x, hp);
      PH_RC_LOW: x = rc_low(x, hp);
      PH_RC_RISE: x.s = go_clkhi(x.s, PH_RC_NEXT);
      PH_RC_NEXT: begin
        x.s.bit_cnt = bit_inc;
        if (bit_inc < RECOVERY_PULSES) begin
          x = rc_low(x, hp);
        end else begin
          x.s.stage = STAGE_FINAL;
          x = st_begin(x, hp);
        end
      end
      PH_RC_OK: x = complete(x, state.held_status);
      default: x.s.phase = PH_IDLE;
    endcase
  end

  always_comb begin
    res.scl_release  = x.s.scl_drive;
    res.sda_release  = x.s.sda_drive;
    res.busy_res     = (x.s.phase != PH_IDLE);
    res.byte_request = (x.s.phase == PH_NEEDBYTE);
    res.read_valid   = x.r.read_valid;
    res.read_byte    = x.r.read_byte;
    res.read_last    = x.r.read_last;
    res.done_res     = x.r.done;
    res.status       = x.r.status;
    res.errors_seen  = x.s.err_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
    end else if (advance) begin
      state <= x.s;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2c_master_with_bus_recovery_core.sv]
// Top level of the I2C master with bus recovery: handshake, configuration and result register.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one bus tick: it carries the sampled SCL and SDA levels and an
// optional command, and produces exactly one result transfer with the new line drives and
// status. One tick is accepted every clock cycle unless in_stall holds it; a tick passes through
// the input register and then the result register, and the sequencer state advances as the
// tick moves from the input register into the result register. Configuration writes take
// effect at once and belong only to idle periods.
`include "assert_macros.svh"

module i2c_master_with_bus_recovery_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [6:0]  address,
  input  wire logic [7:0]  reg_index,
  input  wire logic [15:0] length,
  input  wire logic [7:0]  data_byte,
  input  wire logic        scl_level,
  input  wire logic        sda_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_release,
  output logic             sda_release,
  output logic             busy_res,
  output logic             byte_request,
  output logic             read_valid,
  output logic [7:0]       read_byte,
  output logic             read_last,
  output logic             done_res,
  output logic [2:0]       status,
  output logic [15:0]      errors_seen
);
  import i2cm_pkg::*;

  cfg_t    cfg;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    take_in;
  result_t res_next;
  result_t res;

  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period      <= 16'd5;
      cfg.stretch_timeout  <= 16'd1000;
      cfg.bus_free_timeout <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: cfg.half_period      <= cfg_data;
        CFG_STRETCH:     cfg.stretch_timeout  <= cfg_data;
        CFG_BUS_FREE:    cfg.bus_free_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take_in) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (take_in) begin
      held_item <= '{opcode: opcode, address: address, reg_index: reg_index,
                     length: length, data_byte: data_byte,
                     scl_level: scl_level, sda_level: sda_level};
    end
  end

  i2cm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign scl_release  = res.scl_release;
  assign sda_release  = res.sda_release;
  assign busy_res     = res.busy_res;
  assign byte_request = res.byte_request;
  assign read_valid   = res.read_valid;
  assign read_byte    = res.read_byte;
  assign read_last    = res.read_last;
  assign done_res     = res.done_res;
  assign status       = res.status;
  assign errors_seen  = res.errors_seen;

  `I2CM_ASSERT(a_advance_fills, clk, rst, advance |=> out_valid, "tick lost after advance")
  `I2CM_ASSERT(a_done_xor_read, clk, rst, out_valid |-> !(read_valid && done_res), "done with read byte")
  `I2CM_ASSERT(a_status_done, clk, rst, (out_valid && status != ST_OK) |-> done_res, "status without done")
  `I2CM_ASSERT(a_err_monotonic, clk, rst, (advance && $past(advance) && !$past(rst)) |=> (errors_seen >= $past(errors_seen)), "error count fell")
  `I2CM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && !held_valid), "valid after reset")

endmodule

`default_nettype wire

[verif/i2c_master_with_bus_recovery_core_tb.sv]
// Self-checking testbench for the I2C master core with a line-level slave model and predictor.
`timescale 1ns / 1ps

module i2c_master_with_bus_recovery_core_tb;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [6:0]  address;
  logic [7:0]  reg_index;
  logic [15:0] length;
  logic [7:0]  data_byte;
  logic        scl_level;
  logic        sda_level;
  logic        out_valid;
  logic        out_stall;
  logic        scl_release;
  logic        sda_release;
  logic        busy_res;
  logic        byte_request;
  logic        read_valid;
  logic [7:0]  read_byte;
  logic        read_last;
  logic        done_res;
  logic [2:0]  status;
  logic [15:0] errors_seen;

  i2c_master_with_bus_recovery_core dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predicted sequencer state and configuration.
  phase_t      ph, ph_ret;
  logic [3:0]  bits;
  logic [15:0] bytes_done, dly, wt, errs, hlen;
  logic [7:0]  shreg, hreg;
  logic [6:0]  haddr;
  status_t     hstat;
  logic [1:0]  hkind, stg, brole;
  logic        nacked, scl_d, sda_d;
  logic [15:0] hp, stretch_to, free_to;
  logic        o_rv, o_rl, o_dn;
  logic [7:0]  o_rb;
  status_t     o_st;
  item_t       cur;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          commands_sent = 0;
  int          reads_seen = 0;
  bit          quiet = 1'b0;
  bit          hold_scl_low = 1'b0;
  bit          hold_sda_low = 1'b0;
  int          stretch_left = 0;
  int          stretch_max = 3;
  int          nack_odds = 12;
  int          stall_left = 0;

  function automatic bit arm_delay(phase_t ret);
    dly = (hp == 16'd0) ? 16'd1 : hp;
    ph_ret = ret;
    ph = PH_DELAY;
    return 1'b0;
  endfunction

  function automatic bit arm_clock_high(phase_t ret);
    scl_d = 1'b1;
    wt = 16'd0;
    ph_ret = ret;
    ph = PH_CLKHI;
    return 1'b1;
  endfunction

  function automatic bit arm_bus_free(phase_t ret);
    scl_d = 1'b1;
    sda_d = 1'b1;
    wt = 16'd0;
    ph_ret = ret;
    ph = PH_WAITFREE;
    return 1'b1;
  endfunction

  function automatic bit finish_xfer(status_t st);
    o_dn = 1'b1;
    o_st = st;
    scl_d = 1'b1;
    sda_d = 1'b1;
    ph = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic void count_error();
    if (errs != 16'hFFFF) errs = errs + 16'd1;
  endfunction

  function automatic bit abort_xfer(status_t code);
    if (stg == STAGE_XFER) begin
      hstat = code;
      stg = STAGE_STOP;
      ph = PH_ST_BEGIN;
      return 1'b0;
    end
    if (stg == STAGE_STOP) begin
      if (hstat == ST_OK) hstat = code;
      count_error();
      stg = STAGE_RECOVER;
      ph = PH_RC_BEGIN;
      return 1'b0;
    end
    if (hkind == KIND_RECOVER) hstat = code;
    return finish_xfer(hstat);
  endfunction

  function automatic bit enter_stop();
    stg = STAGE_STOP;
    ph = PH_ST_BEGIN;
    return 1'b0;
  endfunction

  function automatic bit open_xfer(logic [1:0] kind);
    hkind = kind;
    haddr = cur.address;
    hreg = cur.reg_index;
    hlen = cur.length;
    hstat = ST_OK;
    stg = STAGE_XFER;
    bytes_done = 16'd0;
    brole = ROLE_ADDR;
    shreg = {cur.address, 1'b0};
    return arm_bus_free(PH_START_SDA);
  endfunction

  function automatic bit byte_sent();
    if (nacked) return abort_xfer(ST_NACK);
    if (brole == ROLE_ADDR) begin
      if (hkind == KIND_WRITE) begin
        ph = PH_NEEDBYTE;
        return 1'b0;
      end
      if (hkind == KIND_READ) begin
        shreg = hreg;
        brole = ROLE_REG;
        bits = 4'd0;
        ph = PH_WB_BIT;
        return 1'b0;
      end
      return enter_stop();
    end
    if (brole == ROLE_REG) begin
      ph = PH_RS_BEGIN;
      return 1'b0;
    end
    if (brole == ROLE_RADDR) begin
      bytes_done = 16'd0;
      ph = PH_RB_BEGIN;
      return 1'b0;
    end
    if (bytes_done != 16'hFFFF) bytes_done = bytes_done + 16'd1;
    if (bytes_done < hlen) begin
      ph = PH_NEEDBYTE;
      return 1'b0;
    end
    return enter_stop();
  endfunction

  function automatic bit run_sequencer();
    case (ph)
      PH_IDLE: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        if (cur.opcode == OP_PROBE) return open_xfer(KIND_PROBE);
        if (cur.opcode == OP_WRITE || cur.opcode == OP_READ) begin
          if (cur.length == 16'd0) return finish_xfer(ST_ARG);
          return open_xfer((cur.opcode == OP_WRITE) ? KIND_WRITE : KIND_READ);
        end
        if (cur.opcode == OP_RECOVER) begin
          hkind = KIND_RECOVER;
          hstat = ST_OK;
          stg = STAGE_RECOVER;
          ph = PH_RC_BEGIN;
          return 1'b0;
        end
        return 1'b1;
      end
      PH_DELAY: begin
        if (dly > 16'd0) dly = dly - 16'd1;
        if (dly == 16'd0) ph = ph_ret;
        return 1'b1;
      end
      PH_CLKHI: begin
        scl_d = 1'b1;
        if (cur.scl_level) return arm_delay(ph_ret);
        if (wt != 16'hFFFF) wt = wt + 16'd1;
        if (wt >= stretch_to) return abort_xfer(ST_TIMEOUT);
        return 1'b1;
      end
      PH_WAITFREE: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        if (cur.scl_level && cur.sda_level) begin
          ph = ph_ret;
          return 1'b0;
        end
        if (wt != 16'hFFFF) wt = wt + 16'd1;
        if (wt >= free_to) return abort_xfer(ST_STUCK);
        return 1'b1;
      end
      PH_START_SDA: begin
        sda_d = 1'b0;
        return arm_delay(PH_START_SCL);
      end
      PH_START_SCL: begin
        scl_d = 1'b0;
        bits = 4'd0;
        return arm_delay(PH_WB_BIT);
      end
      PH_WB_BIT: begin
        if (bits < BITS_PER_BYTE) begin
          sda_d = shreg[7];
          return arm_delay(PH_WB_RISE);
        end
        sda_d = 1'b1;
        return arm_delay(PH_WB_ACKRISE);
      end
      PH_WB_RISE: return arm_clock_high(PH_WB_FALL);
      PH_WB_FALL: begin
        scl_d = 1'b0;
        shreg = {shreg[6:0], 1'b0};
        bits = bits + 4'd1;
        return arm_delay(PH_WB_BIT);
      end
      PH_WB_ACKRISE: return arm_clock_high(PH_WB_ACKSAMPLE);
      PH_WB_ACKSAMPLE: begin
        nacked = cur.sda_level;
        scl_d = 1'b0;
        return arm_delay(PH_WB_AFTER);
      end
      PH_WB_AFTER: return byte_sent();
      PH_NEEDBYTE: begin
        if (cur.opcode == OP_SUPPLY) begin
          shreg = cur.data_byte;
          bits = 4'd0;
          brole = ROLE_DATA;
          ph = PH_WB_BIT;
          return 1'b0;
        end
        return 1'b1;
      end
      PH_RS_BEGIN: begin
        sda_d = 1'b1;
        shreg = {haddr, 1'b1};
        brole = ROLE_RADDR;
        return arm_delay(PH_RS_RISE);
      end
      PH_RS_RISE: return arm_clock_high(PH_START_SDA);
      PH_RB_BEGIN: begin
        sda_d = 1'b1;
        bits = 4'd0;
        shreg = 8'd0;
        ph = PH_RB_RISE;
        return 1'b0;
      end
      PH_RB_RISE: return arm_clock_high(PH_RB_SAMPLE);
      PH_RB_SAMPLE: begin
        shreg = {shreg[6:0], cur.sda_level};
        bits = bits + 4'd1;
        scl_d = 1'b0;
        return arm_delay((bits < BITS_PER_BYTE) ? PH_RB_RISE : PH_RB_ACK);
      end
      PH_RB_ACK: begin
        sda_d = ({1'b0, bytes_done} + 17'd1 < {1'b0, hlen}) ? 1'b0 : 1'b1;
        return arm_delay(PH_RB_ACKRISE);
      end
      PH_RB_ACKRISE: return arm_clock_high(PH_RB_ACKFALL);
      PH_RB_ACKFALL: begin
        scl_d = 1'b0;
        return arm_delay(PH_RB_END);
      end
      PH_RB_END: begin
        sda_d = 1'b1;
        o_rv = 1'b1;
        o_rb = shreg;
        o_rl = ({1'b0, bytes_done} + 17'd1 >= {1'b0, hlen});
        if (bytes_done != 16'hFFFF) bytes_done = bytes_done + 16'd1;
        if (bytes_done < hlen) begin
          ph = PH_RB_BEGIN;
          return 1'b0;
        end
        return enter_stop();
      end
      PH_ST_BEGIN: begin
        sda_d = 1'b0;
        return arm_delay(PH_ST_RISE);
      end
      PH_ST_RISE: return arm_clock_high(PH_ST_END);
      PH_ST_END: begin
        sda_d = 1'b1;
        return arm_delay(PH_ST_DONE);
      end
      PH_ST_DONE: begin
        if (stg == STAGE_STOP) begin
          if (hstat == ST_OK) return finish_xfer(ST_OK);
          count_error();
          stg = STAGE_RECOVER;
          ph = PH_RC_BEGIN;
          return 1'b0;
        end
        return arm_bus_free(PH_RC_OK);
      end
      PH_RC_BEGIN: begin
        sda_d = 1'b1;
        bits = 4'd0;
        ph = PH_RC_LOW;
        return 1'b0;
      end
      PH_RC_LOW: begin
        scl_d = 1'b0;
        return arm_delay(PH_RC_RISE);
      end
      PH_RC_RISE: return arm_clock_high(PH_RC_NEXT);
      PH_RC_NEXT: begin
        bits = bits + 4'd1;
        if (bits < RECOVERY_PULSES) begin
          ph = PH_RC_LOW;
          return 1'b0;
        end
        stg = STAGE_FINAL;
        ph = PH_ST_BEGIN;
        return 1'b0;
      end
      PH_RC_OK: return finish_xfer(hstat);
      default: begin
        ph = PH_IDLE;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic result_t bus_tick(item_t it);
    result_t r;
    cur = it;
    o_rv = 1'b0;
    o_rb = 8'd0;
    o_rl = 1'b0;
    o_dn = 1'b0;
    o_st = ST_OK;
    for (int g = 0; g < 32; g++) begin
      if (run_sequencer()) break;
    end
    r.scl_release = scl_d;
    r.sda_release = sda_d;
    r.busy_res = (ph != PH_IDLE);
    r.byte_request = (ph == PH_NEEDBYTE);
    r.read_valid = o_rv;
    r.read_byte = o_rb;
    r.read_last = o_rl;
    r.done_res = o_dn;
    r.status = o_st;
    r.errors_seen = errs;
    return r;
  endfunction

  // Sends one tick whose line levels come from the slave model and the predicted drives.
  task automatic send_tick(logic [2:0] op, logic [6:0] addr, logic [7:0] rg,
                           logic [15:0] len, logic [7:0] db);
    item_t it;
    bit slave_sda;
    int gap;
    if (stretch_left > 0) stretch_left--;
    else if (scl_d && $urandom_range(0, 19) == 0) stretch_left = $urandom_range(1, stretch_max);
    if (ph == PH_WB_ACKSAMPLE) slave_sda = ($urandom_range(0, nack_odds - 1) == 0);
    else if (ph == PH_RB_SAMPLE) slave_sda = 1'($urandom_range(0, 1));
    else slave_sda = ($urandom_range(0, 59) != 0);
    it.opcode = op;
    it.address = addr;
    it.reg_index = rg;
    it.length = len;
    it.data_byte = db;
    it.scl_level = scl_d && stretch_left == 0 && !(hold_scl_low && ph != PH_WAITFREE);
    it.sda_level = sda_d && slave_sda && !hold_sda_low;
    opcode <= it.opcode;
    address <= it.address;
    reg_index <= it.reg_index;
    length <= it.length;
    data_byte <= it.data_byte;
    scl_level <= it.scl_level;
    sda_level <= it.sda_level;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(bus_tick(it));
    ticks_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One ordinary tick: may supply a byte when asked, otherwise mostly a plain tick.
  task automatic background_tick();
    logic [2:0] op;
    op = OP_TICK;
    if (ph == PH_NEEDBYTE && $urandom_range(0, 1) == 0) op = OP_SUPPLY;
    else if ($urandom_range(0, 7) == 0) op = 3'($urandom_range(0, 7));
    if (ph == PH_IDLE && op != OP_SUPPLY && op < 3'd6) op = OP_TICK;
    send_tick(op, 7'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic run_command(logic [2:0] op, logic [6:0] addr, logic [7:0] rg,
                             logic [15:0] len, logic [7:0] db);
    send_tick(op, addr, rg, len, db);
    commands_sent++;
    while (ph != PH_IDLE) background_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALF_PERIOD: hp = value;
      CFG_STRETCH:     stretch_to = value;
      default:         free_to = value;
    endcase
  endtask

  task automatic random_command();
    logic [2:0] op;
    logic [15:0] len;
    op = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 15) == 0) len = 16'd0;
    else if (op == OP_WRITE && $urandom_range(0, 29) == 0) len = 16'($urandom);
    else len = 16'($urandom_range(1, 3));
    run_command(op, 7'($urandom), 8'($urandom), len, 8'($urandom));
  endtask

  task automatic test_basic_commands();
    run_command(OP_PROBE, 7'h7F, 8'h00, 16'd1, 8'h00);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    run_command(OP_WRITE, 7'h55, 8'h00, 16'd2, 8'hFF);
    run_command(OP_READ, 7'h2A, 8'hFF, 16'd3, 8'h00);
    run_command(OP_RECOVER, 7'h00, 8'h00, 16'd0, 8'h00);
    run_command(OP_WRITE, 7'h12, 8'h34, 16'd0, 8'h00);
    run_command(OP_READ, 7'h12, 8'h34, 16'd0, 8'h00);
    run_command(OP_SUPPLY, 7'h00, 8'h00, 16'd1, 8'hA5);
    run_command(3'd6, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF);
    run_command(3'd7, 7'h00, 8'h00, 16'd0, 8'h00);
    nack_odds = 3;
    run_command(OP_WRITE, 7'h3C, 8'h00, 16'hFFFF, 8'h5A);
    nack_odds = 12;
  endtask

  task automatic test_stretch_timeout();
    write_reg(CFG_STRETCH, 16'd2);
    hold_scl_low = 1'b1;
    run_command(OP_PROBE, 7'h21, 8'h00, 16'd1, 8'h00);
    run_command(OP_RECOVER, 7'h00, 8'h00, 16'd1, 8'h00);
    hold_scl_low = 1'b0;
    stretch_max = 5;
    random_command();
    stretch_max = 3;
  endtask

  task automatic test_stuck_bus();
    write_reg(CFG_BUS_FREE, 16'd4);
    hold_sda_low = 1'b1;
    run_command(OP_WRITE, 7'h40, 8'h00, 16'd1, 8'h00);
    run_command(OP_RECOVER, 7'h00, 8'h00, 16'd1, 8'h00);
    hold_sda_low = 1'b0;
    write_reg(CFG_BUS_FREE, 16'd1);
    random_command();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    run_command(OP_WRITE, 7'h01, 8'h02, 16'd0, 8'h00);
    repeat (3) background_tick();
    write_reg(CFG_STRETCH, 16'hFFFF);
    write_reg(CFG_BUS_FREE, 16'hFFFF);
    write_reg(CFG_HALF_PERIOD, 16'd0);
    random_command();
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_STRETCH, 16'd1);
    random_command();
  endtask

  task automatic test_random_traffic();
    int pass_end;
    for (int cfg_pass = 0; cfg_pass < 4; cfg_pass++) begin
      write_reg(CFG_HALF_PERIOD, 16'($urandom_range(1, 3)));
      write_reg(CFG_STRETCH, 16'($urandom_range(2, 12)));
      write_reg(CFG_BUS_FREE, 16'($urandom_range(2, 40)));
      if (cfg_pass == 3) quiet = 1'b1;
      pass_end = 1150 * (cfg_pass + 1) / 4;
      if (pass_end < ticks_sent + 40) pass_end = ticks_sent + 40;
      while (ticks_sent < pass_end) begin
        if (ph == PH_IDLE && $urandom_range(0, 2) == 0) random_command();
        else background_tick();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 13);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.read_valid) reads_seen++;
        check_field("scl_release", 16'(want.scl_release), 16'(scl_release));
        check_field("sda_release", 16'(want.sda_release), 16'(sda_release));
        check_field("busy_res", 16'(want.busy_res), 16'(busy_res));
        check_field("byte_request", 16'(want.byte_request), 16'(byte_request));
        check_field("read_valid", 16'(want.read_valid), 16'(read_valid));
        check_field("read_byte", 16'(want.read_byte), 16'(read_byte));
        check_field("read_last", 16'(want.read_last), 16'(read_last));
        check_field("done_res", 16'(want.done_res), 16'(done_res));
        check_field("status", 16'(want.status), 16'(status));
        check_field("errors_seen", want.errors_seen, errors_seen);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_with_bus_recovery_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_HALF_PERIOD;
    cfg_data = 16'd0;
    in_valid = 1'b0;
    opcode = OP_TICK;
    address = 7'd0;
    reg_index = 8'd0;
    length = 16'd0;
    data_byte = 8'd0;
    scl_level = 1'b1;
    sda_level = 1'b1;
    out_stall = 1'b0;
    ph = PH_IDLE;
    ph_ret = PH_IDLE;
    bits = 4'd0;
    bytes_done = 16'd0;
    dly = 16'd0;
    wt = 16'd0;
    errs = 16'd0;
    hlen = 16'd0;
    shreg = 8'd0;
    hreg = 8'd0;
    haddr = 7'd0;
    hstat = ST_OK;
    hkind = KIND_PROBE;
    stg = STAGE_XFER;
    brole = ROLE_ADDR;
    nacked = 1'b0;
    scl_d = 1'b1;
    sda_d = 1'b1;
    hp = 16'd5;
    stretch_to = 16'd1000;
    free_to = 16'd1000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_commands();
    test_stretch_timeout();
    test_stuck_bus();
    test_register_extremes();
    test_random_traffic();
    drain();
    $display("Covered %0d ticks and %0d commands; %0d results checked, %0d read bytes.",
             ticks_sent, commands_sent, results_seen, reads_seen);
    $display("Final error count of the block: %0d.", errs);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("i2c_master_with_bus_recovery_core_tb: done, clean");
    end else begin
      $display("i2c_master_with_bus_recovery_core_tb: done, errors");
    end
    $finish;
  end

endmodule
